/* src/sbss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sbss_pkg;

  // fixed field widths
  localparam int unsigned AddrW    = 64;
  localparam int unsigned WordW    = 64;
  localparam int unsigned LenW     = 5;
  localparam int unsigned CapW     = 16;
  localparam int unsigned TotalW   = 13;
  localparam int unsigned WinBytes = 16;
  localparam int unsigned FillW    = 4;
  localparam int unsigned CfgIdxW  = 3;

  // input action codes
  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_SCAN = 1'b1;

  // result kind codes
  localparam logic KIND_HIT  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_RANGE_START  = 3'd0,
    REG_RANGE_END    = 3'd1,
    REG_PATTERN_LOW  = 3'd2,
    REG_PATTERN_HIGH = 3'd3,
    REG_PATTERN_LEN  = 3'd4,
    REG_MAX_HITS     = 3'd5
  } cfg_reg_e;

  // outcome of a scan start, decided in the front
  typedef enum logic [1:0] {
    START_BAD  = 2'd0,
    START_NONE = 2'd1,
    START_RUN  = 2'd2
  } start_code_e;

  // one classified input beat
  typedef struct packed {
    logic              is_start;
    logic [7:0]        data;
    logic              readable;
    start_code_e       code;
    logic [CapW-1:0]   cap;
  } item_t;

  // live configuration seen by the back end
  typedef struct packed {
    logic [AddrW-1:0] range_start;
    logic [AddrW-1:0] range_end;
    logic [WordW-1:0] pattern_low;
    logic [WordW-1:0] pattern_high;
    logic [LenW-1:0]  pattern_len;
  } scan_cfg_t;

  // one result beat
  typedef struct packed {
    logic              kind;
    logic [AddrW-1:0]  hit_address;
    logic [WordW-1:0]  captured_low;
    logic [WordW-1:0]  captured_high;
    logic [TotalW-1:0] hit_total;
    logic              overflowed;
    logic              status;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

/* src/sbss_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sbss_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       readable;

  modport source (output valid, output action, output data_byte, output readable,
                  input ready);
  modport sink   (input valid, input action, input data_byte, input readable,
                  output ready);
endinterface

`default_nettype wire

/* src/sbss_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sbss_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] hit_address;
  logic [63:0] captured_low;
  logic [63:0] captured_high;
  logic [12:0] hit_total;
  logic        overflowed;
  logic        status;
  logic        last;

  modport source (output valid, output kind, output hit_address, output captured_low,
                  output captured_high, output hit_total, output overflowed,
                  output status, output last, input ready);
  modport sink   (input valid, input kind, input hit_address, input captured_low,
                  input captured_high, input hit_total, input overflowed,
                  input status, input last, output ready);
endinterface

`default_nettype wire

/* src/sbss_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module sbss_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* src/sbss_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module sbss_front
  import sbss_pkg::*;
#(
  parameter int unsigned PatternMax  = 16,
  parameter int unsigned DefaultHits = 256,
  parameter int unsigned HardCap     = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [WordW-1:0]   cfg_wdata_i,
  sbss_in_if.sink                 item_i,
  input  wire logic               queue_full_i,
  output logic                    push_o,
  output item_t                   item_o,
  output scan_cfg_t               cfg_o
);

  scan_cfg_t       cfg_q;
  logic [CapW-1:0] max_hits_q;
  logic [CapW-1:0] cap_req;
  logic [AddrW-1:0] span;
  start_code_e     code;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= '0;
      max_hits_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RANGE_START:  cfg_q.range_start  <= cfg_wdata_i;
        REG_RANGE_END:    cfg_q.range_end    <= cfg_wdata_i;
        REG_PATTERN_LOW:  cfg_q.pattern_low  <= cfg_wdata_i;
        REG_PATTERN_HIGH: cfg_q.pattern_high <= cfg_wdata_i;
        REG_PATTERN_LEN:  cfg_q.pattern_len  <= cfg_wdata_i[LenW-1:0];
        REG_MAX_HITS:     max_hits_q         <= cfg_wdata_i[CapW-1:0];
        default: ;
      endcase
    end
  end

  // classify a scan start against the current configuration
  always_comb begin
    span = cfg_q.range_end - cfg_q.range_start;
    if (cfg_q.pattern_len == '0 || cfg_q.pattern_len > LenW'(PatternMax) ||
        cfg_q.range_end <= cfg_q.range_start) begin
      code = START_BAD;
    end else if (span < AddrW'(cfg_q.pattern_len)) begin
      code = START_NONE;
    end else begin
      code = START_RUN;
    end
    cap_req = (max_hits_q == '0) ? CapW'(DefaultHits) : max_hits_q;
    if (cap_req > CapW'(HardCap)) begin
      cap_req = CapW'(HardCap);
    end
  end

  // accept a beat whenever the queue has room
  assign item_i.ready     = !queue_full_i;
  assign push_o           = item_i.valid && !queue_full_i;
  assign item_o.is_start  = (item_i.action == ACTION_SCAN);
  assign item_o.data      = item_i.data_byte;
  assign item_o.readable  = item_i.readable;
  assign item_o.code      = code;
  assign item_o.cap       = cap_req;
  assign cfg_o            = cfg_q;

endmodule

`default_nettype wire

/* src/sbss_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module sbss_back
  import sbss_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      queue_empty_i,
  input  item_t          item_i,
  input  scan_cfg_t      cfg_i,
  output logic           pop_o,
  input  wire logic      res_full_i,
  output logic           res_push_o,
  output result_t        res_o
);

  logic                   active_q, active_d;
  logic                   pend_q, pend_d;
  logic [FillW-1:0]       fill_q, fill_d;
  logic [WinBytes-1:0][7:0] win_q, win_d;
  logic                   all_rd_q, all_rd_d;
  logic [CapW-1:0]        hits_q, hits_d;
  logic [AddrW-1:0]       win_addr_q, win_addr_d;
  logic [AddrW-1:0]       rem_q, rem_d;
  logic [LenW-1:0]        len_q, len_d;
  logic [CapW-1:0]        cap_q, cap_d;
  logic [WinBytes-1:0][7:0] pat_q, pat_d;

  logic [WinBytes-1:0][7:0] win_new;
  logic                   rd_new;
  logic                   match;
  logic                   complete;
  logic                   last_win;
  logic [AddrW-1:0]       rem_next;

  // incoming byte merged into the window, parallel compare
  always_comb begin
    win_new = win_q;
    win_new[fill_q] = item_i.data;
    rd_new  = all_rd_q && item_i.readable;
    match   = rd_new;
    for (int i = 0; i < WinBytes; i++) begin
      if (LenW'(i) < len_q && win_new[i] != pat_q[i]) begin
        match = 1'b0;
      end
    end
    complete = ((LenW'(fill_q) + LenW'(1)) == len_q);
    rem_next = rem_q - AddrW'(1);
    last_win = (rem_next < AddrW'(len_q));
  end

  // scan sequencing
  always_comb begin
    active_d   = active_q;
    pend_d     = pend_q;
    fill_d     = fill_q;
    win_d      = win_q;
    all_rd_d   = all_rd_q;
    hits_d     = hits_q;
    win_addr_d = win_addr_q;
    rem_d      = rem_q;
    len_d      = len_q;
    cap_d      = cap_q;
    pat_d      = pat_q;
    pop_o      = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    res_o.kind = KIND_DONE;
    res_o.last = 1'b1;
    res_o.hit_total = hits_q[TotalW-1:0];

    if (!res_full_i) begin
      if (pend_q) begin
        // trailing summary after the last window's hit
        res_push_o = 1'b1;
        pend_d     = 1'b0;
      end else if (!queue_empty_i) begin
        pop_o = 1'b1;
        if (item_i.is_start) begin
          active_d   = 1'b0;
          fill_d     = '0;
          win_d      = '0;
          all_rd_d   = 1'b1;
          hits_d     = '0;
          win_addr_d = cfg_i.range_start;
          rem_d      = cfg_i.range_end - cfg_i.range_start;
          len_d      = cfg_i.pattern_len;
          cap_d      = item_i.cap;
          pat_d      = {cfg_i.pattern_high, cfg_i.pattern_low};
          res_o.hit_total = '0;
          unique case (item_i.code)
            START_BAD: begin
              res_push_o   = 1'b1;
              res_o.status = STATUS_BAD;
            end
            START_NONE: begin
              res_push_o = 1'b1;
            end
            START_RUN: begin
              active_d = 1'b1;
            end
            default: ;
          endcase
        end else if (active_q) begin
          rem_d = rem_next;
          if (complete) begin
            fill_d     = '0;
            win_d      = '0;
            all_rd_d   = 1'b1;
            win_addr_d = win_addr_q + AddrW'(len_q);
            if (match && hits_q >= cap_q) begin
              // limit reached: summary with overflow, scan stops
              res_push_o       = 1'b1;
              res_o.overflowed = 1'b1;
              active_d         = 1'b0;
            end else if (match) begin
              res_push_o          = 1'b1;
              res_o.kind          = KIND_HIT;
              res_o.last          = 1'b0;
              res_o.hit_address   = win_addr_q;
              res_o.captured_low  = win_new[7:0];
              res_o.captured_high = win_new[15:8];
              hits_d              = hits_q + CapW'(1);
              res_o.hit_total     = hits_d[TotalW-1:0];
              if (last_win) begin
                pend_d   = 1'b1;
                active_d = 1'b0;
              end
            end else if (last_win) begin
              res_push_o = 1'b1;
              active_d   = 1'b0;
            end
          end else begin
            fill_d   = fill_q + FillW'(1);
            win_d    = win_new;
            all_rd_d = rd_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      pend_q     <= 1'b0;
      fill_q     <= '0;
      win_q      <= '0;
      all_rd_q   <= 1'b1;
      hits_q     <= '0;
      win_addr_q <= '0;
      rem_q      <= '0;
      len_q      <= '0;
      cap_q      <= '0;
      pat_q      <= '0;
    end else begin
      active_q   <= active_d;
      pend_q     <= pend_d;
      fill_q     <= fill_d;
      win_q      <= win_d;
      all_rd_q   <= all_rd_d;
      hits_q     <= hits_d;
      win_addr_q <= win_addr_d;
      rem_q      <= rem_d;
      len_q      <= len_d;
      cap_q      <= cap_d;
      pat_q      <= pat_d;
    end
  end

endmodule

`default_nettype wire

/* src/strided_byte_signature_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

// Strided byte signature scan.
// Configuration: write range, signature, length and hit limit through the
// cfg_we_i / cfg_idx_i / cfg_wdata_i port while the block is idle; a scan
// start beat snapshots them.
// Input channel item_i: one beat per byte (action 0) or a scan start
// (action 1). Output channel result_o: hit records and at most one done
// summary per scan (none if a new start cuts it off), flagged with last.
// Throughput: one input beat per cycle while the output queue has room. A
// window that is both a hit and the last of the range produces two results,
// and the scan engine takes no input beat while it pushes the second one.
// Path: a beat is written into the input queue; the scan engine pops it and
// pushes the result it causes into the output queue, whose head drives
// result_o. The summary that follows a last-window hit is pushed after that hit.
// Stalls: when result_o is not ready the output queue fills, the scan engine
// holds, and the input queue absorbs up to QueueDepth beats before
// item_i.ready drops.
// Reset: all queues empty, no scan active, configuration registers zero.
module strided_byte_signature_scan
  import sbss_pkg::*;
#(
  parameter int unsigned PatternMax  = 16,
  parameter int unsigned DefaultHits = 256,
  parameter int unsigned HardCap     = 4096,
  parameter int unsigned QueueDepth  = 4,
  parameter int unsigned OutDepth    = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [WordW-1:0]   cfg_wdata_i,
  sbss_in_if.sink                 item_i,
  sbss_out_if.source              result_o
);

  item_t     item_push, item_head;
  scan_cfg_t cfg;
  logic      q_push, q_pop, q_full, q_empty;
  result_t   res_push_data, res_head;
  logic      res_push, res_full, res_empty;

  // front: config registers and beat classification
  sbss_front #(
    .PatternMax  (PatternMax),
    .DefaultHits (DefaultHits),
    .HardCap     (HardCap)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_i       (item_i),
    .queue_full_i (q_full),
    .push_o       (q_push),
    .item_o       (item_push),
    .cfg_o        (cfg)
  );

  // queue between front and scan engine
  sbss_fifo #(
    .Width ($bits(item_t)),
    .Depth (QueueDepth)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (item_push),
    .pop_i   (q_pop),
    .rdata_o (item_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: window assembly, compare and result generation
  sbss_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (q_empty),
    .item_i        (item_head),
    .cfg_i         (cfg),
    .pop_o         (q_pop),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_o         (res_push_data)
  );

  // output queue decouples the receiver
  sbss_fifo #(
    .Width ($bits(result_t)),
    .Depth (OutDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_push_data),
    .pop_i   (result_o.ready),
    .rdata_o (res_head),
    .full_o  (res_full),
    .empty_o (res_empty)
  );

  assign result_o.valid         = !res_empty;
  assign result_o.kind          = res_head.kind;
  assign result_o.hit_address   = res_head.hit_address;
  assign result_o.captured_low  = res_head.captured_low;
  assign result_o.captured_high = res_head.captured_high;
  assign result_o.hit_total     = res_head.hit_total;
  assign result_o.overflowed    = res_head.overflowed;
  assign result_o.status        = res_head.status;
  assign result_o.last          = res_head.last;

endmodule

`default_nettype wire

/* tb/sbss_checker.sv */
`timescale 1ns / 1ps

// watches the config port and both channels, predicts every result beat
// and compares accepted result beats against the oldest prediction
module sbss_checker
  import sbss_pkg::*;
#(
  parameter int unsigned PatternMax  = 16,
  parameter int unsigned DefaultHits = 256,
  parameter int unsigned HardCap     = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [WordW-1:0]   cfg_wdata_i,
  sbss_in_if                      item_i,
  sbss_out_if                     result_i,
  output int unsigned             mismatch_count_o,
  output int unsigned             outstanding_o,
  output int unsigned             hit_count_o,
  output int unsigned             done_count_o,
  output int unsigned             cutoff_count_o,
  output int unsigned             reject_count_o
);

  // registers as last written
  logic [AddrW-1:0] reg_range_start;
  logic [AddrW-1:0] reg_range_end;
  logic [WordW-1:0] reg_sig_low;
  logic [WordW-1:0] reg_sig_high;
  logic [LenW-1:0]  reg_sig_len;
  logic [CapW-1:0]  reg_hit_limit;

  // snapshot taken at scan start, and scan progress
  logic [AddrW-1:0] scan_base;
  logic [AddrW-1:0] scan_span;
  logic [AddrW-1:0] bytes_taken;
  logic [WordW-1:0] sig_low;
  logic [WordW-1:0] sig_high;
  int unsigned      sig_len;
  int unsigned      hit_cap;
  int unsigned      win_fill;
  int unsigned      hits_so_far;
  logic [7:0]       win_bytes [WinBytes];
  logic             win_readable;
  logic             limit_hit;
  logic             scanning;

  result_t          expected_results [$];

  int unsigned mismatches   = 0;
  int unsigned outstanding  = 0;
  int unsigned hits_seen    = 0;
  int unsigned dones_seen   = 0;
  int unsigned cutoffs_seen = 0;
  int unsigned rejects_seen = 0;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = outstanding;
  assign hit_count_o      = hits_seen;
  assign done_count_o     = dones_seen;
  assign cutoff_count_o   = cutoffs_seen;
  assign reject_count_o   = rejects_seen;

  function automatic void clear_window();
    for (int i = 0; i < WinBytes; i++) win_bytes[i] = '0;
    win_fill     = 0;
    win_readable = 1'b1;
  endfunction

  function automatic void wipe_state();
    reg_range_start = '0;
    reg_range_end   = '0;
    reg_sig_low     = '0;
    reg_sig_high    = '0;
    reg_sig_len     = '0;
    reg_hit_limit   = '0;
    scan_base       = '0;
    scan_span       = '0;
    bytes_taken     = '0;
    sig_low         = '0;
    sig_high        = '0;
    sig_len         = 0;
    hit_cap         = 0;
    hits_so_far     = 0;
    limit_hit       = 1'b0;
    scanning        = 1'b0;
    clear_window();
    expected_results.delete();
    outstanding = 0;
  endfunction

  function automatic void write_register(input logic [CfgIdxW-1:0] idx,
                                         input logic [WordW-1:0] value);
    case (cfg_reg_e'(idx))
      REG_RANGE_START:  reg_range_start = value;
      REG_RANGE_END:    reg_range_end   = value;
      REG_PATTERN_LOW:  reg_sig_low     = value;
      REG_PATTERN_HIGH: reg_sig_high    = value;
      REG_PATTERN_LEN:  reg_sig_len     = value[LenW-1:0];
      REG_MAX_HITS:     reg_hit_limit   = value[CapW-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] latched_sig_byte(input int unsigned i);
    if (i < 8) return sig_low[i*8 +: 8];
    return sig_high[(i-8)*8 +: 8];
  endfunction

  function automatic void push_summary(input logic status);
    result_t r;
    r            = '0;
    r.kind       = KIND_DONE;
    r.hit_total  = hits_so_far[TotalW-1:0];
    r.overflowed = limit_hit;
    r.status     = status;
    r.last       = 1'b1;
    expected_results.push_back(r);
  endfunction

  // one accepted input beat: update the scan and queue what it produces
  function automatic void predict_beat(input logic act, input logic [7:0] data,
                                       input logic rd);
    result_t          r;
    logic [WordW-1:0] cap_low;
    logic [WordW-1:0] cap_high;
    logic             match;
    int unsigned      i;
    if (act == ACTION_SCAN) begin
      bytes_taken = '0;
      clear_window();
      hits_so_far = 0;
      limit_hit   = 1'b0;
      scanning    = 1'b0;
      if (reg_sig_len == 0 || reg_sig_len > PatternMax ||
          reg_range_end <= reg_range_start) begin
        push_summary(STATUS_BAD);
        return;
      end
      scan_base = reg_range_start;
      scan_span = reg_range_end - reg_range_start;
      sig_low   = reg_sig_low;
      sig_high  = reg_sig_high;
      sig_len   = reg_sig_len;
      hit_cap   = (reg_hit_limit == 0) ? DefaultHits : reg_hit_limit;
      if (hit_cap > HardCap) hit_cap = HardCap;
      // range too short for even one window
      if (scan_span < AddrW'(sig_len)) begin
        push_summary(STATUS_OK);
        return;
      end
      scanning = 1'b1;
      return;
    end
    // bytes outside a scan are dropped
    if (!scanning) return;
    if (win_fill < WinBytes) win_bytes[win_fill] = data;
    win_fill++;
    if (!rd) win_readable = 1'b0;
    bytes_taken++;
    if (win_fill < sig_len) return;
    match = win_readable;
    for (i = 0; i < sig_len; i++) begin
      if (win_bytes[i] != latched_sig_byte(i)) match = 1'b0;
    end
    if (match) begin
      // a match past the limit ends the scan with only the summary
      if (hits_so_far >= hit_cap) begin
        limit_hit = 1'b1;
        scanning  = 1'b0;
        push_summary(STATUS_OK);
        return;
      end
      cap_low  = '0;
      cap_high = '0;
      for (i = 0; i < sig_len; i++) begin
        if (i < 8) cap_low[i*8 +: 8] = win_bytes[i];
        else cap_high[(i-8)*8 +: 8] = win_bytes[i];
      end
      hits_so_far++;
      r               = '0;
      r.kind          = KIND_HIT;
      r.hit_address   = scan_base + (bytes_taken - AddrW'(sig_len));
      r.captured_low  = cap_low;
      r.captured_high = cap_high;
      r.hit_total     = hits_so_far[TotalW-1:0];
      r.status        = STATUS_OK;
      expected_results.push_back(r);
    end
    clear_window();
    // no complete window left in the range
    if (scan_span - bytes_taken < AddrW'(sig_len)) begin
      scanning = 1'b0;
      push_summary(STATUS_OK);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (result_i.kind == KIND_HIT) hits_seen++;
    else begin
      dones_seen++;
      if (result_i.overflowed) cutoffs_seen++;
      if (result_i.status == STATUS_BAD) rejects_seen++;
    end
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: result beat, expected none, actual kind %0d address %h total %0d last %0d",
               $time, result_i.kind, result_i.hit_address, result_i.hit_total,
               result_i.last);
      return;
    end
    want = expected_results.pop_front();
    compare_field("kind", want.kind, result_i.kind);
    compare_field("hit_address", want.hit_address, result_i.hit_address);
    compare_field("captured_low", want.captured_low, result_i.captured_low);
    compare_field("captured_high", want.captured_high, result_i.captured_high);
    compare_field("hit_total", want.hit_total, result_i.hit_total);
    compare_field("overflowed", want.overflowed, result_i.overflowed);
    compare_field("status", want.status, result_i.status);
    compare_field("last", want.last, result_i.last);
  endfunction

  // sample everything at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_state();
    end else begin
      if (cfg_we_i) write_register(cfg_idx_i, cfg_wdata_i);
      if (item_i.valid && item_i.ready) begin
        predict_beat(item_i.action, item_i.data_byte, item_i.readable);
      end
      if (result_i.valid && result_i.ready) check_result();
      outstanding = expected_results.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import sbss_pkg::*;

  localparam int unsigned PatternMax  = 16;
  localparam int unsigned DefaultHits = 256;
  localparam int unsigned HardCap     = 4096;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned PhaseBeats  = 75;

  localparam logic [AddrW-1:0]   TopAddr     = '1;
  localparam logic [CfgIdxW-1:0] RegSpareLow = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareTop = 3'd7;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [WordW-1:0]   cfg_wdata_i = '0;

  sbss_in_if  item_ch ();
  sbss_out_if result_ch ();

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned hit_count;
  int unsigned done_count;
  int unsigned cutoff_count;
  int unsigned reject_count;

  // stimulus-side copy of the registers, used to shape byte content
  logic [AddrW-1:0] cfg_start;
  logic [AddrW-1:0] cfg_end;
  logic [WordW-1:0] cfg_sig_low;
  logic [WordW-1:0] cfg_sig_high;
  logic [LenW-1:0]  cfg_sig_len;
  logic [CapW-1:0]  cfg_limit;

  int unsigned source_idle_pct = 0;
  int unsigned sink_stall_pct  = 0;
  int unsigned beats_sent      = 0;
  int unsigned scans_run       = 0;
  int unsigned quiet_cycles    = 0;

  strided_byte_signature_scan #(
    .PatternMax (PatternMax),
    .DefaultHits(DefaultHits),
    .HardCap    (HardCap)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_ch),
    .result_o   (result_ch)
  );

  sbss_checker #(
    .PatternMax (PatternMax),
    .DefaultHits(DefaultHits),
    .HardCap    (HardCap)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .item_i          (item_ch),
    .result_i        (result_ch),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding),
    .hit_count_o     (hit_count),
    .done_count_o    (done_count),
    .cutoff_count_o  (cutoff_count),
    .reject_count_o  (reject_count)
  );

  // 2 ns clock
  always #1 clk_i = ~clk_i;

  // result backpressure
  always @(negedge clk_i) begin
    result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no beat for %0d cycles, %0d results still expected",
               $time, QuietLimit, outstanding);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] signature_byte(input int unsigned i);
    if (i < 8) return cfg_sig_low[i*8 +: 8];
    return cfg_sig_high[(i-8)*8 +: 8];
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic load_config(input logic [AddrW-1:0] base, input logic [AddrW-1:0] limit,
                             input logic [WordW-1:0] sig_lo, input logic [WordW-1:0] sig_hi,
                             input logic [LenW-1:0] len, input logic [CapW-1:0] cap);
    cfg_start    = base;
    cfg_end      = limit;
    cfg_sig_low  = sig_lo;
    cfg_sig_high = sig_hi;
    cfg_sig_len  = len;
    cfg_limit    = cap;
    write_reg(REG_RANGE_START, base);
    write_reg(REG_RANGE_END, limit);
    write_reg(REG_PATTERN_LOW, sig_lo);
    write_reg(REG_PATTERN_HIGH, sig_hi);
    write_reg(REG_PATTERN_LEN, WordW'(len));
    write_reg(REG_MAX_HITS, WordW'(cap));
    // unmapped indexes must leave the registers alone
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? RegSpareTop : RegSpareLow, {$urandom, $urandom});
    end
  endtask

  // present one beat, with random idle cycles ahead of it
  task automatic send_beat(input logic act, input logic [7:0] data, input logic rd);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < source_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_ch.valid     <= 1'b1;
    item_ch.action    <= act;
    item_ch.data_byte <= data;
    item_ch.readable  <= rd;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_start();
    scans_run++;
    send_beat(ACTION_SCAN, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_byte_random();
    send_beat(ACTION_BYTE, 8'($urandom), $urandom_range(0, 4) != 0);
  endtask

  // one window: mostly the signature, sometimes spoiled by one byte or all random
  task automatic send_window();
    int unsigned mode;
    int unsigned spoil;
    logic [7:0]  data;
    logic        rd;
    mode  = $urandom_range(0, 99);
    spoil = $urandom_range(0, cfg_sig_len - 1);
    for (int unsigned i = 0; i < cfg_sig_len; i++) begin
      data = signature_byte(i);
      rd   = 1'b1;
      if (mode >= 90) begin
        data = 8'($urandom);
        rd   = $urandom_range(0, 4) != 0;
      end else if (mode >= 75 && i == spoil) begin
        data = data ^ 8'(1 << $urandom_range(0, 7));
      end else if (mode >= 60 && i == spoil) begin
        rd = 1'b0;
      end
      send_beat(ACTION_BYTE, data, rd);
    end
  endtask

  // drop valid, wait for every predicted result, then let the pipe empty
  task automatic drain_results();
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // single-byte signature, every byte a match, to run into the hit limit
  task automatic bulk_scan(input logic [CapW-1:0] cap, input int unsigned count);
    load_config(TopAddr - count, TopAddr, {$urandom, $urandom}, {$urandom, $urandom},
                LenW'(1), cap);
    send_start();
    repeat (count) send_beat(ACTION_BYTE, signature_byte(0), 1'b1);
    drain_results();
  endtask

  task automatic random_scan();
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] span;
    logic [AddrW-1:0] limit;
    logic [LenW-1:0]  len;
    logic [CapW-1:0]  cap;
    int unsigned      pick;
    logic             runs;
    pick = $urandom_range(0, 99);
    if (pick < 88) len = LenW'($urandom_range(1, PatternMax));
    else if (pick < 94) len = '0;
    else len = LenW'($urandom_range(PatternMax + 1, 31));
    if ($urandom_range(0, 9) == 0) span = $urandom_range(0, len);
    else span = $urandom_range(len, 48);
    case ($urandom_range(0, 9))
      0:       base = '0;
      1:       base = TopAddr - span;
      default: base = {$urandom, $urandom};
    endcase
    if (base > TopAddr - span) base = TopAddr - span;
    limit = base + span;
    // now and then an empty or reversed range
    if ($urandom_range(0, 19) == 0) limit = (base >= span) ? base - span : base;
    case ($urandom_range(0, 9))
      0:       cap = '0;
      1:       cap = CapW'(HardCap);
      2:       cap = '1;
      3, 4, 5: cap = CapW'($urandom_range(1, 4));
      default: cap = CapW'($urandom);
    endcase
    load_config(base, limit, {$urandom, $urandom}, {$urandom, $urandom}, len, cap);
    runs = (len != 0) && (len <= PatternMax) && (limit > base) && (limit - base >= len);
    send_start();
    if (runs && $urandom_range(0, 9) == 0) begin
      // abandon the scan part way and restart on the same registers
      repeat ($urandom_range(1, 2 * len)) send_byte_random();
      send_start();
    end
    if (runs) begin
      repeat ((limit - base) / len) send_window();
      repeat ((limit - base) % len) send_byte_random();
    end
    repeat ($urandom_range(0, 2)) send_byte_random();
    drain_results();
  endtask

  task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned goal;
    source_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    goal            = beats_sent + PhaseBeats;
    while (beats_sent < goal) random_scan();
  endtask

  initial begin
    item_ch.valid     = 1'b0;
    item_ch.action    = ACTION_BYTE;
    item_ch.data_byte = '0;
    item_ch.readable  = 1'b0;
    result_ch.ready   = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    source_idle_pct = 6;
    sink_stall_pct  = 77;

    // bytes with no scan running, then a start on the reset registers
    send_beat(ACTION_BYTE, 8'hff, 1'b1);
    send_beat(ACTION_BYTE, 8'h00, 1'b0);
    send_start();
    drain_results();

    // rejected setups: oversized signature, empty range, reversed range
    write_reg(RegSpareLow, '1);
    write_reg(RegSpareTop, '1);
    load_config(64'h0, 64'h40, '1, '1, LenW'(PatternMax + 1), '0);
    send_start();
    drain_results();
    load_config(64'h1000, 64'h1000, '0, '0, LenW'(4), '0);
    send_start();
    drain_results();
    load_config(64'h1000, 64'h0fff, '0, '0, LenW'(4), '0);
    send_start();
    drain_results();

    // range shorter than the signature
    load_config(64'h20, 64'h23, {$urandom, $urandom}, '0, LenW'(4), '0);
    send_start();
    drain_results();

    // full-width signature ending at the top address, last window is a hit
    load_config(TopAddr - PatternMax, TopAddr, 64'h0123_4567_89ab_cdef,
                64'hfedc_ba98_7654_3210, LenW'(PatternMax), '1);
    send_start();
    for (int unsigned i = 0; i < PatternMax; i++) begin
      send_beat(ACTION_BYTE, signature_byte(i), 1'b1);
    end
    drain_results();

    // limit of one: hit, unreadable match, mismatch, cut off, then ignored
    load_config('0, 64'h8, 64'hffff_ffff_ffff_ffa5, '1, LenW'(1), CapW'(1));
    send_start();
    send_beat(ACTION_BYTE, 8'ha5, 1'b1);
    send_beat(ACTION_BYTE, 8'ha5, 1'b0);
    send_beat(ACTION_BYTE, 8'h5a, 1'b1);
    send_beat(ACTION_BYTE, 8'ha5, 1'b1);
    send_beat(ACTION_BYTE, 8'ha5, 1'b1);
    drain_results();

    // default limit runs out
    bulk_scan('0, DefaultHits + 44);

    random_phase(6, 77);
    random_phase(77, 6);
    random_phase(0, 0);

    $display("covered %0d scans and %0d input beats over three idling mixes",
             scans_run, beats_sent);
    $display("results: %0d hit records, %0d done summaries, %0d cut off, %0d rejected",
             hit_count, done_count, cutoff_count, reject_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatch_count, outstanding);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
